[rtl/core/mexp_pkg.sv]
// Shared widths, register indexes and sequencer states for the modular exponentiation unit.
`timescale 1ns / 1ps

package mexp_pkg;

	localparam int WORD_WIDTH = 16;
	// 2*acc + a stays below 3*m, so two bits of headroom
	localparam int ACC_W = WORD_WIDTH + 2;
	localparam int CNT_W = $clog2(WORD_WIDTH + 1);
	localparam int BIT_W = $clog2(WORD_WIDTH);
	localparam int CFG_IDX_W = 2;

	typedef logic [WORD_WIDTH-1:0] word_t;
	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_MODULUS = 2'd0;
	localparam cfg_idx_t REG_PRIV_EXP = 2'd1;
	localparam cfg_idx_t REG_PUB_EXP = 2'd2;

	localparam word_t MODULUS_RST = word_t'(2);
	localparam word_t EXP_RST = word_t'(1);
	localparam word_t WORD_ONE = word_t'(1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_REDUCE,
		ST_PICK,
		ST_MUL,
		ST_SQR,
		ST_DONE
	} mexp_state_t;

	// Handshake toward the bit-serial multiplier
	typedef struct packed {
		logic start;
		word_t a;
		word_t b;
	} mexp_mul_req_t;

	typedef struct packed {
		logic done;
		word_t prod;
	} mexp_mul_rsp_t;

endpackage

[rtl/core/mexp_modmul.sv]
// Bit-serial interleaved modular multiplier: one multiplier bit per cycle, MSB first.
`timescale 1ns / 1ps

module mexp_modmul (
	input  logic                   clk,
	input  logic                   arst_n,
	input  mexp_pkg::mexp_mul_req_t req,
	input  mexp_pkg::word_t        modulus,
	output mexp_pkg::mexp_mul_rsp_t rsp
);
	import mexp_pkg::*;

	logic             busy_q;
	logic [CNT_W-1:0] cnt_q;
	word_t            a_q;
	word_t            b_q;
	word_t            m_q;
	word_t            acc_q;

	logic [ACC_W-1:0] t;
	logic [ACC_W-1:0] m1;
	logic [ACC_W-1:0] m2;
	word_t            acc_nxt;

	// Double, add a when the current multiplier bit is set, then fold back below m
	always_comb begin
		m1 = ACC_W'(m_q);
		m2 = {1'b0, m_q, 1'b0};
		t = {1'b0, acc_q, 1'b0} + (b_q[WORD_WIDTH-1] ? ACC_W'(a_q) : '0);
		if (t >= m2) begin
			acc_nxt = WORD_WIDTH'(t - m2);
		end else if (t >= m1) begin
			acc_nxt = WORD_WIDTH'(t - m1);
		end else begin
			acc_nxt = WORD_WIDTH'(t);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (req.start) begin
			busy_q <= 1'b1;
			cnt_q <= CNT_W'(WORD_WIDTH);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			a_q <= req.a;
			b_q <= req.b;
			m_q <= modulus;
			acc_q <= '0;
		end else if (busy_q) begin
			acc_q <= acc_nxt;
			b_q <= {b_q[WORD_WIDTH-2:0], 1'b0};
		end
	end

	assign rsp.done = busy_q && (cnt_q == CNT_W'(1));
	assign rsp.prod = acc_nxt;

endmodule

[rtl/core/modular_exponentiation_unit.sv]
// Top level: configuration registers, square-and-multiply sequencer and result strobe.
`timescale 1ns / 1ps

// Computes value^e mod modulus for one 16-bit word at a time, e being the
// private exponent when mode is 0 and the public exponent when mode is 1.
// Pulse start while busy is low to hand in a word; busy stays high until the
// result has been shown. The result appears on result for exactly one cycle
// with result_valid high and must be taken then: there is no way to hold it
// off. The bit-serial modular multiplier retires one multiplier bit per cycle;
// one product reduces the input, then each of the 16 exponent bits costs one
// scheduling state, one squaring and, when the bit is set, one more product.
// A modulus below 2 gives 0. The configuration channel is always ready;
// write it only while busy is low. A zero exponent gives 1, and a value at or
// above the modulus is reduced first.
module modular_exponentiation_unit (
	input  logic                  clk,
	input  logic                  arst_n,
	// command side
	input  logic                  start,
	output logic                  busy,
	input  logic                  mode,
	input  mexp_pkg::word_t       value,
	// result side
	output logic                  result_valid,
	output mexp_pkg::word_t       result,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  mexp_pkg::cfg_idx_t    cfg_index,
	input  mexp_pkg::word_t       cfg_data
);
	import mexp_pkg::*;

	word_t            modulus_q;
	word_t            priv_exp_q;
	word_t            pub_exp_q;

	mexp_state_t      state_q;
	mexp_state_t      state_nxt;
	word_t            exp_q;      // exponent, shifted right one bit per round
	logic [BIT_W-1:0] bit_q;      // exponent bit under work
	word_t            acc_q;      // running product
	word_t            sq_q;       // running square of the reduced value

	mexp_mul_req_t    mul_req;
	mexp_mul_rsp_t    mul_rsp;

	logic             mod_small;
	logic             last_bit;

	assign cfg_ready = 1'b1;
	assign mod_small = (modulus_q < word_t'(2));
	assign last_bit = (bit_q == BIT_W'(WORD_WIDTH - 1));

	// Configuration registers: take a word on every valid, drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			modulus_q <= MODULUS_RST;
			priv_exp_q <= EXP_RST;
			pub_exp_q <= EXP_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MODULUS:  modulus_q <= cfg_data;
				REG_PRIV_EXP: priv_exp_q <= cfg_data;
				REG_PUB_EXP:  pub_exp_q <= cfg_data;
				default: ;
			endcase
		end
	end

	mexp_modmul u_modmul (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mul_req),
		.modulus (modulus_q),
		.rsp     (mul_rsp)
	);

	// Sequencer: next state and multiplier launches
	always_comb begin
		state_nxt = state_q;
		mul_req.start = 1'b0;
		mul_req.a = sq_q;
		mul_req.b = sq_q;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					if (mod_small) begin
						state_nxt = ST_DONE;
					end else begin
						// value * 1 mod m reduces the input word
						mul_req.start = 1'b1;
						mul_req.a = WORD_ONE;
						mul_req.b = value;
						state_nxt = ST_REDUCE;
					end
				end
			end
			ST_REDUCE: begin
				if (mul_rsp.done) begin
					state_nxt = ST_PICK;
				end
			end
			ST_PICK: begin
				mul_req.start = 1'b1;
				if (exp_q[0]) begin
					mul_req.a = acc_q;
					state_nxt = ST_MUL;
				end else begin
					state_nxt = ST_SQR;
				end
			end
			ST_MUL: begin
				// squaring follows straight on; sq holds until it finishes
				if (mul_rsp.done) begin
					mul_req.start = 1'b1;
					state_nxt = ST_SQR;
				end
			end
			ST_SQR: begin
				if (mul_rsp.done) begin
					state_nxt = last_bit ? ST_DONE : ST_PICK;
				end
			end
			ST_DONE: begin
				state_nxt = ST_IDLE;
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	// Datapath registers: load on an accepted start, advance on multiplier completion
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					exp_q <= mode ? pub_exp_q : priv_exp_q;
					bit_q <= '0;
					acc_q <= mod_small ? '0 : WORD_ONE;
				end
			end
			ST_REDUCE: begin
				if (mul_rsp.done) begin
					sq_q <= mul_rsp.prod;
				end
			end
			ST_MUL: begin
				if (mul_rsp.done) begin
					acc_q <= mul_rsp.prod;
				end
			end
			ST_SQR: begin
				if (mul_rsp.done) begin
					sq_q <= mul_rsp.prod;
					exp_q <= {1'b0, exp_q[WORD_WIDTH-1:1]};
					bit_q <= bit_q + BIT_W'(1);
				end
			end
			default: ;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	// One-cycle strobe; the running product is final in the done state
	assign result_valid = (state_q == ST_DONE);
	assign result = acc_q;

endmodule

[rtl/core/mexp_checker.sv]
// Port-level checks on the command and result handshake of the modular exponentiation unit.
`timescale 1ns / 1ps

module mexp_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic result_valid
);

	// Strobe lasts one cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |=> !result_valid)
		else $error("result strobe longer than one cycle");

	// A result only shows while a word is in flight
	assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> busy)
		else $error("result strobe while idle");

	// An accepted word makes the block busy
	assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted word did not raise busy");

	// Busy drops only right after the result was shown
	assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> $past(result_valid))
		else $error("busy dropped without a result");

endmodule

bind modular_exponentiation_unit mexp_checker u_mexp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.start        (start),
	.busy         (busy),
	.result_valid (result_valid)
);

[tb/tb_modular_exponentiation_unit.sv]
// Self-checking testbench for the modular exponentiation unit: directed and random words.
`timescale 1ns / 1ps

module tb_modular_exponentiation_unit;

	import mexp_pkg::*;

	// Mode bit codes: which configured exponent the block raises the word to
	localparam logic MODE_ENCRYPT = 1'b0;
	localparam logic MODE_DECRYPT = 1'b1;

	// Index 3 maps to no register; a write there must leave every register unchanged
	localparam cfg_idx_t REG_UNUSED = 2'd3;

	// No busy stretch of the block comes near this limit and the sender gaps are short,
	// so this many quiet cycles in a row means the block has hung.
	localparam int WATCHDOG_LIMIT = 5000;
	// Longest busy stretch, rounded up: the settling wait at the end of the run
	localparam int DRAIN_CYCLES = 600;

	localparam int WORDS_PER_CONFIG = 50;
	localparam int CONFIGS_PER_PHASE = 5;
	// Percent of cycles in which the sender holds off, one entry per phase.
	// The result side cannot stall, so the phases meant for it run with no idling.
	localparam int IDLE_PLAN [4] = '{0, 72, 0, 8};

	// Shadow of the configuration registers plus the queue of powers still owed
	class mexp_scoreboard;
		word_t modulus = MODULUS_RST;
		word_t priv_exp = EXP_RST;
		word_t pub_exp = EXP_RST;
		word_t expected_powers [$];
		int errors = 0;

		function void apply_reg(cfg_idx_t idx, word_t data);
			case (idx)
			REG_MODULUS: modulus = data;
			REG_PRIV_EXP: priv_exp = data;
			REG_PUB_EXP: pub_exp = data;
			default: ;
			endcase
		endfunction

		// Right-to-left square-and-multiply; operands stay below 2^16, so products fit in 32 bits
		function word_t pow_mod(word_t base, word_t expo, word_t m);
			logic [31:0] acc;
			logic [31:0] sq;
			if (m < 2)
				return '0;
			acc = 32'(WORD_ONE);
			sq = 32'(base % m);
			for (int i = 0; i < WORD_WIDTH; i++) begin
				if (expo[i])
					acc = (acc * sq) % 32'(m);
				sq = (sq * sq) % 32'(m);
			end
			return word_t'(acc);
		endfunction

		function void note_word(logic md, word_t v);
			word_t want;
			want = pow_mod(v, (md == MODE_DECRYPT) ? pub_exp : priv_exp, modulus);
			expected_powers.insert(expected_powers.size(), want);
		endfunction

		task report_mismatch(string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			errors++;
		endtask

		task check_result(word_t got);
			word_t want;
			if (expected_powers.size() == 0) begin
				report_mismatch($sformatf("result %h with no word pending", got));
				return;
			end
			want = expected_powers.pop_front();
			if (got !== want)
				report_mismatch($sformatf("result %h, expected %h", got, want));
		endtask

		function int pending();
			return expected_powers.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic mode;
	word_t value;
	logic result_valid;
	word_t result;
	logic cfg_valid;
	logic cfg_ready;
	cfg_idx_t cfg_index;
	word_t cfg_data;

	mexp_scoreboard pow_ledger = new;
	int sender_idle_pct = 0;
	int quiet_cycles = 0;

	always #2 clk = ~clk;

	modular_exponentiation_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.mode(mode),
		.value(value),
		.result_valid(result_valid),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Monitor: everything the block takes or gives is sampled at the rising edge.
	// Note an accepted word before checking a result: the queue is in order either way,
	// so a word going in on the edge that retires the previous one is handled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				pow_ledger.apply_reg(cfg_index, cfg_data);
			if (start && !busy)
				pow_ledger.note_word(mode, value);
			if (result_valid)
				pow_ledger.check_result(result);
		end
	end

	// Watchdog: count cycles in which no word, result or register write is moved
	always @(posedge clk) begin
		if (!arst_n || (start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles == WATCHDOG_LIMIT) begin
			$display("modular_exponentiation_unit regression: fail");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Present one word and hold it until the block takes it. Return at the falling edge
	// after acceptance with start still high, so a back-to-back word needs no second
	// assignment to start in the same step; the next call or await_idle decides.
	task automatic send_word(input logic md, input word_t v);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		start <= 1'b1;
		mode <= md;
		value <= v;
		do @(posedge clk); while (busy);
		@(negedge clk);
	endtask

	// Drop start, then wait until every owed result has come back and busy is low
	task automatic await_idle();
		start <= 1'b0;
		while (pow_ledger.pending() != 0 || busy)
			@(negedge clk);
	endtask

	// Leave cfg_valid high on return, for the same reason as send_word
	task automatic write_reg(input cfg_idx_t idx, input word_t data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
	endtask

	// Write all three registers, poke the unused index with noise, then drop valid
	task automatic write_config(input word_t m, input word_t priv, input word_t pub);
		write_reg(REG_MODULUS, m);
		write_reg(REG_PRIV_EXP, priv);
		write_reg(REG_UNUSED, word_t'($urandom));
		write_reg(REG_PUB_EXP, pub);
		cfg_valid <= 1'b0;
	endtask

	function automatic word_t pick_exponent();
		case ($urandom_range(0, 7))
		0: return '0;
		1: return '1;
		2: return WORD_ONE;
		default: return word_t'($urandom);
		endcase
	endfunction

	// Favor ordinary moduli, but keep both extremes and the degenerate ones in the mix
	function automatic word_t pick_modulus();
		case ($urandom_range(0, 19))
		0: return '1;
		1: return word_t'(2);
		2: return word_t'($urandom_range(0, 1));
		3: return word_t'($urandom_range(2, 255));
		default: return word_t'($urandom_range(2, 65535));
		endcase
	endfunction

	// Mostly random words, with the edges around the current modulus hit often
	function automatic word_t pick_value();
		case ($urandom_range(0, 9))
		0: return '0;
		1: return '1;
		2: return pow_ledger.modulus - WORD_ONE;
		3: return pow_ledger.modulus;
		default: return word_t'($urandom);
		endcase
	endfunction

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		mode = MODE_ENCRYPT;
		value = '0;
		cfg_valid = 1'b0;
		cfg_index = REG_MODULUS;
		cfg_data = '0;
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Reset registers: modulus 2, both exponents 1
		send_word(MODE_ENCRYPT, 16'h0000);
		send_word(MODE_DECRYPT, 16'h0001);
		send_word(MODE_ENCRYPT, 16'hFFFF);
		send_word(MODE_DECRYPT, 16'h0002);

		// Largest modulus; zero exponent on encrypt, all-ones exponent on decrypt
		await_idle();
		write_config(16'hFFFF, 16'h0000, 16'hFFFF);
		send_word(MODE_ENCRYPT, 16'h0000);
		send_word(MODE_ENCRYPT, 16'hFFFF);
		send_word(MODE_DECRYPT, 16'hFFFE);
		send_word(MODE_DECRYPT, 16'h0000);
		send_word(MODE_DECRYPT, 16'h0001);
		send_word(MODE_DECRYPT, 16'hAAAA);
		send_word(MODE_ENCRYPT, 16'h5555);

		// Modulus of one: every residue is zero
		await_idle();
		write_reg(REG_MODULUS, 16'h0001);
		cfg_valid <= 1'b0;
		send_word(MODE_ENCRYPT, 16'h1234);
		send_word(MODE_DECRYPT, 16'h0000);

		// Modulus of zero: result is zero as well
		await_idle();
		write_reg(REG_MODULUS, 16'h0000);
		cfg_valid <= 1'b0;
		send_word(MODE_ENCRYPT, 16'h00FF);
		send_word(MODE_DECRYPT, 16'hFFFF);

		// Prime modulus; words at, just under and above it
		await_idle();
		write_config(16'd65521, 16'h8001, 16'h7FFE);
		send_word(MODE_ENCRYPT, 16'd65520);
		send_word(MODE_ENCRYPT, 16'd65521);
		send_word(MODE_DECRYPT, 16'hFFFF);
		send_word(MODE_DECRYPT, 16'h0002);
		send_word(MODE_ENCRYPT, 16'h8000);

		// Smallest proper modulus, so every word but zero and one is out of range
		await_idle();
		write_config(16'h0002, 16'hFFFF, 16'h0000);
		send_word(MODE_ENCRYPT, 16'h0003);
		send_word(MODE_DECRYPT, 16'h0002);
		send_word(MODE_ENCRYPT, 16'hFFFE);

		// Random phases: fresh registers every few dozen words, pacing from IDLE_PLAN
		for (int phase = 0; phase < 4; phase++) begin
			sender_idle_pct = IDLE_PLAN[phase];
			for (int grp = 0; grp < CONFIGS_PER_PHASE; grp++) begin
				await_idle();
				write_config(pick_modulus(), pick_exponent(), pick_exponent());
				repeat (WORDS_PER_CONFIG)
					send_word(logic'($urandom_range(0, 1)), pick_value());
			end
		end

		// Drain, then give a stray result time to show up
		await_idle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (pow_ledger.errors == 0 && pow_ledger.pending() == 0)
			$display("modular_exponentiation_unit regression: pass");
		else
			$display("modular_exponentiation_unit regression: fail");
		$finish;
	end

endmodule
